/* rtl/qe_pkg.sv */
package qe_pkg;

  localparam int CordicSteps = 16;
  localparam int SqrtSteps = 32;
  // Pipeline depth from accepted start to result strobe.
  localparam int Latency = 3 + SqrtSteps + 1 + CordicSteps + 2;

  typedef struct packed {
    logic signed [15:0] quat_w;
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
  } quat_t;

  typedef struct packed {
    logic [15:0] roll_level;
    logic [15:0] pitch_level;
    logic [15:0] yaw_level;
  } levels_t;

  // Operands that ride along the square-root chain.
  typedef struct packed {
    logic signed [31:0] s;
    logic signed [33:0] roll_num;
    logic signed [33:0] roll_den;
    logic signed [33:0] yaw_num;
    logic signed [33:0] yaw_den;
  } side_t;

  typedef struct packed {
    logic signed [37:0] x;
    logic signed [37:0] y;
    logic signed [35:0] z;
  } cord_t;

  localparam logic signed [35:0] PiBam = 36'sd2147483648;

  function automatic logic signed [35:0] atan_bam(input logic [4:0] i);
    logic signed [35:0] a;
    unique case (i)
      5'd0:  a = 36'h020000000;
      5'd1:  a = 36'h012E4051E;
      5'd2:  a = 36'h009FB385B;
      5'd3:  a = 36'h0051111D4;
      5'd4:  a = 36'h0028B0D43;
      5'd5:  a = 36'h00145D7E1;
      5'd6:  a = 36'h000A2F61E;
      5'd7:  a = 36'h000517C55;
      5'd8:  a = 36'h00028BE53;
      5'd9:  a = 36'h000145F2F;
      5'd10: a = 36'h0000A2F98;
      5'd11: a = 36'h0000517CC;
      5'd12: a = 36'h000028BE6;
      5'd13: a = 36'h0000145F3;
      5'd14: a = 36'h00000A2FA;
      5'd15: a = 36'h00000517D;
      5'd16: a = 36'h0000028BE;
      5'd17: a = 36'h00000145F;
      5'd18: a = 36'h000000A30;
      5'd19: a = 36'h000000518;
      5'd20: a = 36'h00000028C;
      5'd21: a = 36'h000000146;
      5'd22: a = 36'h0000000A3;
      5'd23: a = 36'h000000051;
      5'd24: a = 36'h000000029;
      5'd25: a = 36'h000000014;
      5'd26: a = 36'h00000000A;
      5'd27: a = 36'h000000005;
      5'd28: a = 36'h000000003;
      5'd29: a = 36'h000000001;
      5'd30: a = 36'h000000001;
      5'd31: a = 36'h000000000;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Fold a left-half-plane vector into the right half plane by a half turn.
  function automatic cord_t prerotate(input logic signed [37:0] y,
                                      input logic signed [37:0] x);
    cord_t c;
    if (x < 0) begin
      c.x = -x;
      c.y = -y;
      c.z = (y >= 0) ? PiBam : -PiBam;
    end else begin
      c.x = x;
      c.y = y;
      c.z = '0;
    end
    return c;
  endfunction

endpackage

/* rtl/qe_sqrt_cell.sv */
module qe_sqrt_cell import qe_pkg::*; (
  input  logic        clk,
  input  logic [4:0]  step,
  input  logic [63:0] n_in,
  input  logic [63:0] res_in,
  input  side_t       side_in,
  output logic [63:0] n_out,
  output logic [63:0] res_out,
  output side_t       side_out
);

  logic [5:0]  bit_pos;
  logic [63:0] bit_val;
  logic [63:0] trial;

  assign bit_pos = 6'd62 - {step, 1'b0};
  assign bit_val = 64'd1 << bit_pos;
  assign trial   = res_in + bit_val;

  always_ff @(posedge clk) begin
    if (n_in >= trial) begin
      n_out   <= n_in - trial;
      res_out <= (res_in >> 1) + bit_val;
    end else begin
      n_out   <= n_in;
      res_out <= res_in >> 1;
    end
    side_out <= side_in;
  end

endmodule

/* rtl/qe_cordic_cell.sv */
module qe_cordic_cell import qe_pkg::*; (
  input  logic       clk,
  input  logic [4:0] step,
  input  cord_t      cin,
  output cord_t      cout
);

  logic signed [37:0] xs;
  logic signed [37:0] ys;

  assign xs = cin.x >>> step;
  assign ys = cin.y >>> step;

  always_ff @(posedge clk) begin
    if (cin.y >= 0) begin
      cout.x <= cin.x + ys;
      cout.y <= cin.y - xs;
      cout.z <= cin.z + atan_bam(step);
    end else begin
      cout.x <= cin.x - ys;
      cout.y <= cin.y + xs;
      cout.z <= cin.z - atan_bam(step);
    end
  end

endmodule

/* rtl/qe_level.sv */
module qe_level import qe_pkg::*; (
  input  logic               clk,
  input  logic               half_turn,
  input  logic [7:0]         level_count,
  input  logic signed [35:0] angle,
  output logic [15:0]        level
);

  logic signed [35:0] lim;
  logic signed [35:0] clamped;
  logic [32:0]        u;
  logic [40:0]        prod;
  logic [17:0]        q;
  logic [17:0]        top;

  assign lim = half_turn ? (PiBam >>> 1) : PiBam;

  always_comb begin
    if (angle > lim) begin
      clamped = lim;
    end else if (angle < -lim) begin
      clamped = -lim;
    end else begin
      clamped = angle;
    end
  end

  always_ff @(posedge clk) begin
    u <= 33'(clamped + lim);
  end

  // The angle span is 2^32 or 2^31; eight fraction bits come back in.
  assign prod = u * level_count;
  assign q    = half_turn ? prod[40:23] : {1'b0, prod[40:24]};
  assign top  = {2'b00, level_count, 8'd0};

  always_ff @(posedge clk) begin
    level <= (q > top) ? top[15:0] : q[15:0];
  end

endmodule

/* rtl/quaternion_to_euler_quantizer_core.sv */
// Converts one unit quaternion per clock into roll, pitch and yaw levels
// (Z-Y-X order), each scaled onto 0..level_count with 8 fraction bits. The
// block is a fixed pipeline: a start is taken in every cycle, busy stays low,
// and result_valid pulses for one cycle as each start's result leaves the
// pipeline. The receiver cannot stall the block and must take each
// result in the cycle it is shown. The depth is set by the 32-cell
// square-root chain for the pitch cosine and the 16-cell CORDIC chain behind
// it. level_count is written through the cfg channel, which is always ready;
// write it only while no item is in flight.
module quaternion_to_euler_quantizer_core import qe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  quat_t      quat,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  output logic       result_valid,
  output levels_t    result
);

  localparam logic signed [33:0] OneQ30 = 34'sd1073741824;

  logic [7:0]         level_count;
  logic [Latency-1:0] vld;

  logic signed [31:0] p_wx, p_yz, p_wy, p_zx, p_xx, p_yy, p_zz, p_wz, p_xy;
  logic signed [33:0] s_wide;
  side_t              side0;
  logic signed [31:0] s_clamped;
  logic [63:0]        sq_n   [0:SqrtSteps];
  logic [63:0]        sq_res [0:SqrtSteps];
  side_t              sq_side[0:SqrtSteps];
  cord_t              cr_roll [0:CordicSteps];
  cord_t              cr_pitch[0:CordicSteps];
  cord_t              cr_yaw  [0:CordicSteps];
  side_t              last_side;
  logic signed [37:0] cos_val;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_count <= 8'd18;
      vld         <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        level_count <= cfg_data;
      end
      vld <= {vld[Latency-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    p_wx <= quat.quat_w * quat.quat_x;
    p_yz <= quat.quat_y * quat.quat_z;
    p_wy <= quat.quat_w * quat.quat_y;
    p_zx <= quat.quat_z * quat.quat_x;
    p_xx <= quat.quat_x * quat.quat_x;
    p_yy <= quat.quat_y * quat.quat_y;
    p_zz <= quat.quat_z * quat.quat_z;
    p_wz <= quat.quat_w * quat.quat_z;
    p_xy <= quat.quat_x * quat.quat_y;
  end

  assign s_wide = (34'(p_wy) - 34'(p_zx)) <<< 1;

  always_comb begin
    if (s_wide > OneQ30) begin
      s_clamped = 32'(OneQ30);
    end else if (s_wide < -OneQ30) begin
      s_clamped = 32'(-OneQ30);
    end else begin
      s_clamped = 32'(s_wide);
    end
  end

  always_ff @(posedge clk) begin
    side0.s        <= s_clamped;
    side0.roll_num <= (34'(p_wx) + 34'(p_yz)) <<< 1;
    side0.roll_den <= OneQ30 - ((34'(p_xx) + 34'(p_yy)) <<< 1);
    side0.yaw_num  <= (34'(p_wz) + 34'(p_xy)) <<< 1;
    side0.yaw_den  <= OneQ30 - ((34'(p_yy) + 34'(p_zz)) <<< 1);
  end

  always_ff @(posedge clk) begin
    sq_n[0]    <= (64'd1 << 60) - 64'(side0.s * side0.s);
    sq_res[0]  <= '0;
    sq_side[0] <= side0;
  end

  for (genvar k = 0; k < SqrtSteps; k++) begin : g_sqrt
    qe_sqrt_cell u_cell (
      .clk     (clk),
      .step    (5'(k)),
      .n_in    (sq_n[k]),
      .res_in  (sq_res[k]),
      .side_in (sq_side[k]),
      .n_out   (sq_n[k+1]),
      .res_out (sq_res[k+1]),
      .side_out(sq_side[k+1])
    );
  end

  assign last_side = sq_side[SqrtSteps];
  assign cos_val   = 38'(sq_res[SqrtSteps][31:0]);

  always_ff @(posedge clk) begin
    cr_roll[0]  <= prerotate(38'(last_side.roll_num), 38'(last_side.roll_den));
    cr_pitch[0] <= prerotate(38'(last_side.s), cos_val);
    cr_yaw[0]   <= prerotate(38'(last_side.yaw_num), 38'(last_side.yaw_den));
  end

  for (genvar i = 0; i < CordicSteps; i++) begin : g_cordic
    qe_cordic_cell u_roll (
      .clk (clk), .step(5'(i)), .cin(cr_roll[i]), .cout(cr_roll[i+1])
    );
    qe_cordic_cell u_pitch (
      .clk (clk), .step(5'(i)), .cin(cr_pitch[i]), .cout(cr_pitch[i+1])
    );
    qe_cordic_cell u_yaw (
      .clk (clk), .step(5'(i)), .cin(cr_yaw[i]), .cout(cr_yaw[i+1])
    );
  end

  qe_level u_roll_level (
    .clk        (clk),
    .half_turn  (1'b0),
    .level_count(level_count),
    .angle      (cr_roll[CordicSteps].z),
    .level      (result.roll_level)
  );

  qe_level u_pitch_level (
    .clk        (clk),
    .half_turn  (1'b1),
    .level_count(level_count),
    .angle      (cr_pitch[CordicSteps].z),
    .level      (result.pitch_level)
  );

  qe_level u_yaw_level (
    .clk        (clk),
    .half_turn  (1'b0),
    .level_count(level_count),
    .angle      (cr_yaw[CordicSteps].z),
    .level      (result.yaw_level)
  );

  assign result_valid = vld[Latency-1];

endmodule

/* rtl/qe_checker.sv */
module qe_checker import qe_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    start,
  input logic    busy,
  input logic    cfg_ready,
  input logic    result_valid,
  input levels_t result
);

  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised on a fully pipelined block");

  a_cfg_ready: assert property (@(posedge clk) disable iff (rst) cfg_ready)
    else $error("configuration channel not ready");

  a_result_has_start: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start, Latency))
    else $error("result strobe without a matching start transfer");

  a_level_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.roll_level <= 16'd65280 &&
                      result.pitch_level <= 16'd65280 &&
                      result.yaw_level <= 16'd65280))
    else $error("level beyond full scale");

endmodule

bind quaternion_to_euler_quantizer_core qe_checker u_qe_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .cfg_ready   (cfg_ready),
  .result_valid(result_valid),
  .result      (result)
);

/* tb/tb_quaternion_to_euler_quantizer_core.sv */
`timescale 1ns / 1ps

module tb_quaternion_to_euler_quantizer_core;
  import qe_pkg::*;

  localparam longint HalfTurn = 64'sd2147483648;
  localparam longint QuarterTurn = 64'sd1073741824;
  localparam longint OneQ30 = 64'sd1073741824;

  // Binary-angle arctangent steps, pi = 2^31.
  localparam longint AtanStep [16] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
    64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
    64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
    64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D
  };

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    start = 1'b0;
  logic    busy;
  quat_t   quat = '0;
  logic    cfg_valid = 1'b0;
  logic    cfg_ready;
  logic [7:0] cfg_data = '0;
  logic    result_valid;
  levels_t result;

  quaternion_to_euler_quantizer_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .quat(quat),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .result_valid(result_valid), .result(result)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  quat_t   pending_quats[$];
  levels_t expected_levels[$];
  logic [7:0] level_count = 8'd18;
  int mismatches = 0;

  function automatic longint vector_angle(longint y, longint x);
    longint ang, xs, ys;
    ang = 0;
    if (x < 0) begin
      ang = (y >= 0) ? HalfTurn : -HalfTurn;
      x = -x;
      y = -y;
    end
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys;
        y = y - xs;
        ang += AtanStep[i];
      end else begin
        x = x - ys;
        y = y + xs;
        ang -= AtanStep[i];
      end
    end
    return ang;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [15:0] angle_to_level(longint ang, longint lim, int span_shift);
    longint unsigned u, q, top;
    if (ang > lim) ang = lim;
    if (ang < -lim) ang = -lim;
    u = ang + lim;
    q = ((u * level_count) << 8) >> span_shift;
    top = longint'(level_count) << 8;
    if (q > top) q = top;
    if (q > 64'hFFFF) q = 64'hFFFF;
    return q[15:0];
  endfunction

  function automatic levels_t euler_levels(quat_t q);
    longint w, x, y, z, s, c;
    levels_t r;
    w = q.quat_w;
    x = q.quat_x;
    y = q.quat_y;
    z = q.quat_z;
    r.roll_level = angle_to_level(
      vector_angle(2 * (w * x + y * z), OneQ30 - 2 * (x * x + y * y)), HalfTurn, 32);
    s = 2 * (w * y - z * x);
    if (s > OneQ30) s = OneQ30;
    if (s < -OneQ30) s = -OneQ30;
    c = floor_sqrt((64'd1 << 60) - longint'(s * s));
    r.pitch_level = angle_to_level(vector_angle(s, c), QuarterTurn, 31);
    r.yaw_level = angle_to_level(
      vector_angle(2 * (w * z + x * y), OneQ30 - 2 * (y * y + z * z)), HalfTurn, 32);
    return r;
  endfunction

  // Sender: bursts of random length separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;
  always @(posedge clk) begin
    logic take;
    take = !start || !busy;
    if (!rst && start && !busy) expected_levels.push_back(euler_levels(quat));
    if (take) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_quats.size() > 0) begin
        quat <= pending_quats.pop_front();
        start <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 8);
          gap_left = $urandom_range(0, 4);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    levels_t want;
    if (!rst && result_valid) begin
      if (expected_levels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", result);
      end else begin
        want = expected_levels.pop_front();
        if (result.roll_level !== want.roll_level ||
            result.pitch_level !== want.pitch_level ||
            result.yaw_level !== want.yaw_level) begin
          mismatches++;
          if (mismatches <= 10)
            $display("levels mismatch: expected roll %0d pitch %0d yaw %0d, got %0d %0d %0d",
                     want.roll_level, want.pitch_level, want.yaw_level,
                     result.roll_level, result.pitch_level, result.yaw_level);
        end
      end
    end
  end

  function automatic quat_t make_quat(int w, int x, int y, int z);
    quat_t q;
    q.quat_w = w[15:0];
    q.quat_x = x[15:0];
    q.quat_y = y[15:0];
    q.quat_z = z[15:0];
    return q;
  endfunction

  function automatic int rand_word();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  // Scales a random direction to (nearly) unit length.
  function automatic quat_t unit_quat(int w, int x, int y, int z);
    real n, k;
    n = $sqrt(real'(w) * w + real'(x) * x + real'(y) * y + real'(z) * z);
    if (n < 1.0) return make_quat(32767, 0, 0, 0);
    k = 32767.0 / n;
    return make_quat($rtoi(w * k), $rtoi(x * k), $rtoi(y * k), $rtoi(z * k));
  endfunction

  task automatic write_level_count(logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    level_count = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_quats.size() > 0 || start || expected_levels.size() > 0)
      @(posedge clk);
    repeat (Latency + 4) @(posedge clk);
  endtask

  task automatic queue_random(int n);
    int pick, a;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 12) begin
        pending_quats.push_back(unit_quat(rand_word(), rand_word(), rand_word(), rand_word()));
      end else if (pick < 15) begin
        // Near gimbal lock: pitch argument near plus or minus one, some just past it.
        a = 23170 + $urandom_range(0, 40);
        pending_quats.push_back(make_quat($urandom_range(0, 1) ? a : -a, rand_word() >>> 10,
                                          $urandom_range(0, 1) ? a : -a, rand_word() >>> 10));
      end else begin
        pending_quats.push_back(make_quat(rand_word(), rand_word(), rand_word(), rand_word()));
      end
    end
  endtask

  initial begin
    logic [7:0] settings [6] = '{8'd18, 8'd255, 8'd1, 8'd0, 8'd100, 8'd37};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (settings[p]) begin
      write_level_count(p == 5 ? 8'($urandom_range(2, 254)) : settings[p]);
      if (p == 0) begin
        pending_quats.push_back(make_quat(32767, 0, 0, 0));
        pending_quats.push_back(make_quat(-32768, 0, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 0));
        pending_quats.push_back(make_quat(32767, 32767, 32767, 32767));
        pending_quats.push_back(make_quat(-32768, -32768, -32768, -32768));
        pending_quats.push_back(make_quat(0, 32767, 0, 0));
        pending_quats.push_back(make_quat(0, -32768, 0, 0));
        pending_quats.push_back(make_quat(0, 0, 32767, 0));
        pending_quats.push_back(make_quat(0, 0, -32768, 0));
        pending_quats.push_back(make_quat(0, 0, 0, 32767));
        pending_quats.push_back(make_quat(0, 0, 0, -32768));
        pending_quats.push_back(make_quat(23170, 0, 23170, 0));
        pending_quats.push_back(make_quat(23170, 0, -23170, 0));
        pending_quats.push_back(make_quat(23200, 0, 23200, 0));
        pending_quats.push_back(make_quat(23170, 23170, 0, 0));
        pending_quats.push_back(make_quat(-23170, 23170, 0, 0));
        pending_quats.push_back(make_quat(23170, -23170, 0, 0));
        pending_quats.push_back(make_quat(0, 23170, 0, 23170));
        pending_quats.push_back(make_quat(16384, 16384, 16384, 16384));
        pending_quats.push_back(make_quat(-16384, 16384, -16384, 16384));
        pending_quats.push_back(make_quat(32767, 32767, 0, 0));
        pending_quats.push_back(make_quat(1000, 200, -300, 50));
      end
      queue_random(155);
      drain();
    end
    if (expected_levels.size() == 0 && mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule
